[design/gut_pkg.sv]
// shared types, register indexes and mode codes of the upload trigger controller
package gut_pkg;

  // configuration register indexes
  localparam logic [7:0] CfgUploadMode    = 8'd0;
  localparam logic [7:0] CfgUploadSetting = 8'd1;

  // upload mode codes
  localparam logic [7:0] ModeOff      = 8'h00;
  localparam logic [7:0] ModeTime     = 8'h01;
  localparam logic [7:0] ModeDist     = 8'h02;
  localparam logic [7:0] ModeAccTime  = 8'h0B;
  localparam logic [7:0] ModeAccDist  = 8'h0C;
  localparam logic [7:0] ModeAccCount = 8'h0D;

  // odometer difference scale
  localparam logic [31:0] DistScale = 32'd100;

  // default depth of the result queue
  localparam int unsigned ResultDepthDefault = 4;

  // one tick item
  typedef struct packed {
    logic [31:0] odometer;
    logic        link_authenticated;
    logic        receiver_switched_off;
    logic        clear_request;
  } tick_t;

  // one result item
  typedef struct packed {
    logic receiver_command;
    logic last_of_tick;
  } result_t;

  // one configuration write
  typedef struct packed {
    logic [7:0]  index;
    logic [31:0] value;
  } cfg_t;

  // commands raised by one tick: start first, then stop
  typedef struct packed {
    logic valid;
    logic has_start;
    logic has_stop;
  } push_t;

endpackage

[design/gut_stream_if.sv]
// valid/ready channel carrying one payload type
interface gut_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/gut_tick_core.sv]
// configuration registers, run state and per-tick command decision
module gut_tick_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  gut_pkg::cfg_t    cfg_data_i,
  input  logic             tick_accept_i,
  input  gut_pkg::tick_t   tick_data_i,
  output gut_pkg::push_t   push_o
);

  logic [7:0]  upload_mode_q;
  logic [31:0] upload_setting_q;
  logic        started_q, started_d;
  logic        finished_q, finished_d;
  logic [31:0] count_q, count_d;
  logic        has_start, has_stop;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upload_mode_q    <= gut_pkg::ModeOff;
      upload_setting_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_data_i.index == gut_pkg::CfgUploadMode) begin
        upload_mode_q <= cfg_data_i.value[7:0];
      end else if (cfg_data_i.index == gut_pkg::CfgUploadSetting) begin
        upload_setting_q <= cfg_data_i.value;
      end
    end
  end

  // decision for the tick on the input
  always_comb begin
    logic        s, f;
    logic [31:0] c;
    logic [31:0] moved;
    logic        auth, off;
    s     = started_q;
    f     = finished_q;
    c     = count_q;
    moved = '0;
    auth  = tick_data_i.link_authenticated;
    off   = tick_data_i.receiver_switched_off;
    has_start = 1'b0;
    has_stop  = 1'b0;

    // clear request drops a running session
    if (tick_data_i.clear_request && s) begin
      s = 1'b0;
      f = 1'b0;
      c = '0;
    end

    if (upload_mode_q == gut_pkg::ModeOff) begin
      if (s) begin
        s = 1'b0;
        f = 1'b0;
        c = '0;
      end
    end else if (auth) begin
      unique case (upload_mode_q)
        gut_pkg::ModeTime: begin
          c = c + 32'd1;
          if (c == upload_setting_q) begin
            has_start = !off;
            c = '0;
          end
        end
        gut_pkg::ModeDist: begin
          if (!s) begin
            c = tick_data_i.odometer;
            s = 1'b1;
          end
          moved = 32'((tick_data_i.odometer - c) * gut_pkg::DistScale);
          if (moved >= upload_setting_q) begin
            has_start = !off;
            c = tick_data_i.odometer;
          end
        end
        gut_pkg::ModeAccTime, gut_pkg::ModeAccCount: begin
          if (!s) begin
            s = 1'b1;
            has_start = 1'b1;
          end
          if (!f) begin
            c = c + 32'd1;
            if (c == upload_setting_q) begin
              has_stop = 1'b1;
              f = 1'b1;
              c = '0;
            end
          end
        end
        gut_pkg::ModeAccDist: begin
          if (!s) begin
            c = tick_data_i.odometer;
            has_start = 1'b1;
            s = 1'b1;
          end
          moved = 32'((tick_data_i.odometer - c) * gut_pkg::DistScale);
          if (!f && moved >= upload_setting_q) begin
            has_stop = 1'b1;
            f = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    started_d  = tick_accept_i ? s : started_q;
    finished_d = tick_accept_i ? f : finished_q;
    count_d    = tick_accept_i ? c : count_q;
  end

  assign push_o.valid     = tick_accept_i;
  assign push_o.has_start = has_start;
  assign push_o.has_stop  = has_stop;

  // run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q  <= 1'b0;
      finished_q <= 1'b0;
      count_q    <= '0;
    end else begin
      started_q  <= started_d;
      finished_q <= finished_d;
      count_q    <= count_d;
    end
  end

`ifndef SYNTHESIS
  // finished is only ever set within a started session
  a_finished_needs_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |-> started_q)
    else $error("finished without started");

  // a stop command always marks the session finished
  a_stop_sets_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.valid && push_o.has_stop) |=> finished_q)
    else $error("stop issued without finishing");

  // state moves only on an accepted tick
  a_state_holds_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tick_accept_i |=> ($stable(count_q) && $stable(started_q) && $stable(finished_q)))
    else $error("run state changed without a tick");
`endif

endmodule

[design/gut_result_fifo.sv]
// small result queue taking up to two commands per tick, one out per cycle while the receiver is ready
module gut_result_fifo #(
  parameter int unsigned Depth = gut_pkg::ResultDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gut_pkg::push_t   push_i,
  output logic             space_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output gut_pkg::result_t out_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  gut_pkg::result_t        mem_q [Depth];
  logic [PtrW-1:0]         wr_q, rd_q, wr_d, rd_d, wr_next;
  logic [CntW-1:0]         count_q, count_d;
  logic [1:0]              push_num;
  logic                    pop;
  gut_pkg::result_t        entry0, entry1;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  // expand the tick's commands into result items
  always_comb begin
    push_num = '0;
    if (push_i.valid) begin
      push_num = 2'({1'b0, push_i.has_start} + {1'b0, push_i.has_stop});
    end
    entry0.receiver_command = push_i.has_start;
    entry0.last_of_tick     = !(push_i.has_start && push_i.has_stop);
    entry1.receiver_command = 1'b0;
    entry1.last_of_tick     = 1'b1;
  end

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign space_o     = (count_q <= CntW'(Depth - 2));
  assign wr_next     = ptr_inc(wr_q);

  // pointer and fill count update
  always_comb begin
    wr_d = wr_q;
    if (push_num == 2'd1) begin
      wr_d = wr_next;
    end else if (push_num == 2'd2) begin
      wr_d = ptr_inc(wr_next);
    end
    rd_d    = pop ? ptr_inc(rd_q) : rd_q;
    count_d = count_q + CntW'(push_num) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  // storage writes
  always_ff @(posedge clk_i) begin
    if (push_num != 2'd0) begin
      mem_q[wr_q] <= entry0;
    end
    if (push_num == 2'd2) begin
      mem_q[wr_next] <= entry1;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("result queue overfilled");

  a_push_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_num != 2'd0) |-> ((count_q + CntW'(push_num)) <= CntW'(Depth)))
    else $error("push into a full result queue");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_num == 2'd0) |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("fill count wrong after pop");
`endif

endmodule

[design/gnss_upload_trigger_controller.sv]
// top level of the gnss detailed-position upload trigger controller
//
// Channels: tick_i takes one tick item (odometer, link_authenticated,
// receiver_switched_off, clear_request); result_o gives the receiver start
// or stop commands, each flagged last_of_tick on the final command of a
// tick; cfg_i writes upload_mode (index 0) and upload_setting (index 1) and
// is always ready. A tick raises zero, one or two commands, start first.
// A tick's commands are written into the result queue at its transfer and
// reach result_o once the commands ahead of them have gone. Ticks are taken
// one per cycle while tick_i is ready; the result queue drains one command
// per cycle while the receiver is ready. A tick that causes no command
// completes in its transfer cycle. Reset clears the run state, both
// configuration registers and the result queue. When the receiver stalls,
// commands wait in the queue (Depth entries); tick_i drops ready once fewer
// than two entries are free.
module gnss_upload_trigger_controller #(
  parameter int unsigned Depth = gut_pkg::ResultDepthDefault
) (
  input logic   clk_i,
  input logic   rst_ni,
  gut_stream_if.sink   tick_i,
  gut_stream_if.source result_o,
  gut_stream_if.sink   cfg_i
);

  gut_pkg::push_t push;
  logic           space;
  logic           tick_accept;

  assign tick_i.ready = space;
  assign cfg_i.ready  = 1'b1;
  assign tick_accept  = tick_i.valid && space;

  // state and decision
  gut_tick_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_i.valid),
    .cfg_data_i    (cfg_i.data),
    .tick_accept_i (tick_accept),
    .tick_data_i   (tick_i.data),
    .push_o        (push)
  );

  // result queue
  gut_result_fifo #(
    .Depth (Depth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (space),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .out_data_o  (result_o.data)
  );

endmodule

[tb/tb_gnss_upload_trigger_controller.sv]
// self-checking testbench for the gnss upload trigger controller
`timescale 1ns / 1ps

module tb_gnss_upload_trigger_controller;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned ReportMax  = 10;

  // codes that the block must ignore
  localparam logic [7:0] CfgUnusedIndex = 8'hA5;
  localparam logic [7:0] ModeUnknown    = 8'h07;
  localparam logic [7:0] ModeReserved   = 8'hFF;

  typedef enum int {
    PaceFull,
    PaceSenderGaps,
    PaceReceiverStalls,
    PaceBothGaps
  } pace_e;

  logic clk_i;
  logic rst_ni;

  gut_stream_if #(.payload_t(gut_pkg::tick_t))   tick_if ();
  gut_stream_if #(.payload_t(gut_pkg::result_t)) result_if ();
  gut_stream_if #(.payload_t(gut_pkg::cfg_t))    cfg_if ();

  gnss_upload_trigger_controller dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (tick_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  // pending ticks and commands still owed by the block
  gut_pkg::tick_t   tick_q[$];
  gut_pkg::result_t cmd_expect_q[$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  logic [31:0] odo_now;

  // predicted configuration and run state
  logic [7:0]  cfg_mode;
  logic [31:0] cfg_setting;
  logic        run_started;
  logic        run_finished;
  logic [31:0] run_count;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run state goes back to idle only once a run has started
  function automatic void clear_run_state();
    if (run_started) begin
      run_count    = '0;
      run_finished = 1'b0;
      run_started  = 1'b0;
    end
  endfunction

  // scaled odometer move since the base, wrapping at 32 bits
  function automatic logic distance_hit(logic [31:0] odo);
    logic [31:0] moved;
    moved = (odo - run_count) * gut_pkg::DistScale;
    return moved >= cfg_setting;
  endfunction

  // work out the commands raised by one tick and queue them
  function automatic void predict_commands(gut_pkg::tick_t t);
    logic             cmd[2];
    int               n;
    int               k;
    gut_pkg::result_t r;
    n = 0;
    if (t.clear_request) clear_run_state();
    if (cfg_mode == gut_pkg::ModeOff) begin
      clear_run_state();
    end else if (t.link_authenticated) begin
      case (cfg_mode)
        gut_pkg::ModeTime: begin
          run_count = run_count + 32'd1;
          if (run_count == cfg_setting) begin
            if (!t.receiver_switched_off) begin
              cmd[n] = 1'b1;
              n++;
            end
            run_count = '0;
          end
        end
        gut_pkg::ModeDist: begin
          if (!run_started) begin
            run_count   = t.odometer;
            run_started = 1'b1;
          end
          if (distance_hit(t.odometer)) begin
            if (!t.receiver_switched_off) begin
              cmd[n] = 1'b1;
              n++;
            end
            run_count = t.odometer;
          end
        end
        gut_pkg::ModeAccTime, gut_pkg::ModeAccCount: begin
          if (!run_started) begin
            run_started = 1'b1;
            cmd[n] = 1'b1;
            n++;
          end
          if (!run_finished) begin
            run_count = run_count + 32'd1;
            if (run_count == cfg_setting) begin
              cmd[n] = 1'b0;
              n++;
              run_finished = 1'b1;
              run_count    = '0;
            end
          end
        end
        gut_pkg::ModeAccDist: begin
          if (!run_started) begin
            run_count   = t.odometer;
            cmd[n]      = 1'b1;
            n++;
            run_started = 1'b1;
          end
          if (!run_finished && distance_hit(t.odometer)) begin
            cmd[n] = 1'b0;
            n++;
            run_finished = 1'b1;
          end
        end
        default: ;
      endcase
    end
    for (k = 0; k < n; k++) begin
      r.receiver_command = cmd[k];
      r.last_of_tick     = (k == n - 1);
      cmd_expect_q.push_back(r);
    end
  endfunction

  function automatic void log_mismatch(string what, gut_pkg::result_t exp_r,
                                       gut_pkg::result_t got_r);
    mismatch_count++;
    if (mismatch_count <= ReportMax)
      $display("%0t mismatch (%s): expected cmd=%b last=%b, got cmd=%b last=%b",
               $realtime, what, exp_r.receiver_command, exp_r.last_of_tick,
               got_r.receiver_command, got_r.last_of_tick);
  endfunction

  // tick driver: next tick from the queue, with random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      tick_if.valid <= 1'b0;
    end else if (!tick_if.valid || tick_if.ready) begin
      if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        tick_if.valid <= 1'b1;
        tick_if.data  <= tick_q.pop_front();
      end else begin
        tick_if.valid <= 1'b0;
      end
    end
  end

  // monitor: track register writes, check commands, predict per tick transfer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.data.index == gut_pkg::CfgUploadMode)
          cfg_mode = cfg_if.data.value[7:0];
        else if (cfg_if.data.index == gut_pkg::CfgUploadSetting)
          cfg_setting = cfg_if.data.value;
      end
      if (result_if.valid && result_if.ready) begin
        if (cmd_expect_q.size() == 0)
          log_mismatch("no command owed", 'x, result_if.data);
        else if (result_if.data.receiver_command !== cmd_expect_q[0].receiver_command ||
                 result_if.data.last_of_tick !== cmd_expect_q[0].last_of_tick)
          log_mismatch("field", cmd_expect_q.pop_front(), result_if.data);
        else
          void'(cmd_expect_q.pop_front());
      end
      if (tick_if.valid && tick_if.ready) predict_commands(tick_if.data);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic push_tick(logic [31:0] odo, logic auth, logic off, logic clr);
    gut_pkg::tick_t t;
    t.odometer              = odo;
    t.link_authenticated    = auth;
    t.receiver_switched_off = off;
    t.clear_request         = clr;
    tick_q.push_back(t);
  endtask

  // mostly small forward moves, sometimes big jumps or a fresh value
  task automatic push_random_tick(int unsigned clr_pct);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 80) odo_now = odo_now + $urandom_range(20);
    else if (sel < 90) odo_now = odo_now + $urandom;
    else odo_now = $urandom;
    push_tick(odo_now, $urandom_range(99) < 88, $urandom_range(99) < 20,
              $urandom_range(99) < clr_pct);
  endtask

  // hold until every queued tick is sent and every owed command has come
  task automatic wait_results();
    while (tick_q.size() != 0 || tick_if.valid || cmd_expect_q.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{index: idx, value: val};
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // registers change only with the block idle
  task automatic configure(logic [7:0] mode, logic [31:0] setting);
    logic [31:0] upper;
    wait_results();
    repeat (4) @(posedge clk_i);
    upper = $urandom;
    write_reg(gut_pkg::CfgUploadMode, {upper[31:8], mode});
    write_reg(gut_pkg::CfgUploadSetting, setting);
  endtask

  task automatic set_pace(pace_e pace);
    case (pace)
      PaceFull: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      PaceSenderGaps: begin
        send_idle_pct  = 46;
        recv_stall_pct = 0;
      end
      PaceReceiverStalls: begin
        send_idle_pct  = 0;
        recv_stall_pct = 46;
      end
      default: begin
        send_idle_pct  = 11;
        recv_stall_pct = 11;
      end
    endcase
  endtask

  // one random phase, with the sender holding off halfway until all commands are in
  task automatic run_phase(logic [7:0] mode, logic [31:0] setting, int unsigned n_ticks,
                           pace_e pace, int unsigned clr_pct);
    int unsigned i;
    configure(mode, setting);
    set_pace(pace);
    for (i = 0; i < n_ticks / 2; i++) push_random_tick(clr_pct);
    wait_results();
    for (i = n_ticks / 2; i < n_ticks; i++) push_random_tick(clr_pct);
  endtask

  // stimulus
  initial begin
    rst_ni          = 1'b0;
    tick_if.valid   = 1'b0;
    tick_if.data    = '0;
    result_if.ready = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.data     = '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    mismatch_count  = 0;
    cycle_count     = 0;
    odo_now         = '0;
    cfg_mode        = gut_pkg::ModeOff;
    cfg_setting     = '0;
    run_started     = 1'b0;
    run_finished    = 1'b0;
    run_count       = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // an unused register index must change nothing
    write_reg(CfgUnusedIndex, $urandom);

    // mode off: extremes of every field, nothing issued
    configure(gut_pkg::ModeOff, '0);
    push_tick('0, 1'b0, 1'b0, 1'b0);
    push_tick('1, 1'b1, 1'b1, 1'b1);

    // accumulated time, setting one: start and stop on the same tick
    configure(gut_pkg::ModeAccTime, 32'd1);
    push_tick(32'd5, 1'b0, 1'b0, 1'b0);
    push_tick(32'd5, 1'b1, 1'b0, 1'b0);
    push_tick(32'd6, 1'b1, 1'b0, 1'b0);
    push_tick(32'd7, 1'b1, 1'b1, 1'b1);

    // time interval, first match suppressed by receiver off
    configure(gut_pkg::ModeTime, 32'd2);
    push_tick(32'd1, 1'b1, 1'b0, 1'b0);
    push_tick(32'd1, 1'b1, 1'b1, 1'b0);
    push_tick(32'd1, 1'b1, 1'b0, 1'b0);
    push_tick(32'd1, 1'b1, 1'b0, 1'b0);

    // distance interval, zero setting matches every tick, receiver off suppresses the last, backwards move wraps
    configure(gut_pkg::ModeDist, '0);
    push_tick(32'd100, 1'b1, 1'b0, 1'b0);
    push_tick(32'd50, 1'b1, 1'b0, 1'b0);
    push_tick(32'd50, 1'b1, 1'b1, 1'b0);

    // accumulated distance, restarted by a clear
    configure(gut_pkg::ModeAccDist, 32'd500);
    push_tick(32'd1000, 1'b1, 1'b0, 1'b1);
    push_tick(32'd1004, 1'b1, 1'b0, 1'b0);
    push_tick(32'd1005, 1'b1, 1'b0, 1'b0);
    push_tick(32'd0, 1'b1, 1'b0, 1'b0);

    // switching off clears a started run
    configure(gut_pkg::ModeOff, 32'd9);
    push_tick(32'd0, 1'b1, 1'b0, 1'b0);

    // unknown mode does nothing
    configure(ModeUnknown, 32'd3);
    push_tick('1, 1'b1, 1'b0, 1'b0);

    // accumulated count with the largest setting
    configure(gut_pkg::ModeAccCount, '1);
    push_tick('0, 1'b1, 1'b0, 1'b0);

    // random phases across modes, settings and pacing
    run_phase(gut_pkg::ModeTime,     32'd3,     35, PaceFull,           6);
    run_phase(gut_pkg::ModeDist,     32'd600,   35, PaceSenderGaps,     6);
    run_phase(gut_pkg::ModeAccTime,  32'd4,     30, PaceReceiverStalls, 15);
    run_phase(gut_pkg::ModeAccDist,  32'd900,   30, PaceBothGaps,       15);
    run_phase(gut_pkg::ModeAccCount, 32'd2,     30, PaceFull,           15);
    run_phase(gut_pkg::ModeOff,      $urandom,  15, PaceSenderGaps,     6);
    run_phase(gut_pkg::ModeTime,     '1,        20, PaceReceiverStalls, 6);
    run_phase(gut_pkg::ModeDist,     '0,        25, PaceBothGaps,       6);
    run_phase(gut_pkg::ModeAccTime,  32'd1,     30, PaceFull,           30);
    run_phase(gut_pkg::ModeAccDist,  '1,        25, PaceSenderGaps,     10);
    run_phase(ModeReserved,          32'd123,   15, PaceReceiverStalls, 6);
    run_phase(gut_pkg::ModeAccCount, '0,        20, PaceBothGaps,       15);
    run_phase(gut_pkg::ModeDist,     32'd2500,  35, PaceSenderGaps,     6);
    run_phase(gut_pkg::ModeAccDist,  '0,        25, PaceReceiverStalls, 30);
    run_phase(gut_pkg::ModeTime,     32'd1,     30, PaceBothGaps,       6);
    run_phase(gut_pkg::ModeAccTime,  32'd7,     35, PaceSenderGaps,     15);
    run_phase(gut_pkg::ModeDist,     32'd1,     30, PaceReceiverStalls, 6);

    // wind down and report
    wait_results();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
design/gut_pkg.sv
design/gut_stream_if.sv
design/gut_tick_core.sv
design/gut_result_fifo.sv
design/gnss_upload_trigger_controller.sv
tb/tb_gnss_upload_trigger_controller.sv
